// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker, clock clk and active-low reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TRM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("temperature multiplier check failed");

// next-cycle implication
`define TRM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("temperature multiplier check failed");

`endif

// ===== rtl/trm_pkg.sv =====
package trm_pkg;

  // log2 unit: one normalize stage plus one squaring stage per fraction bit
  localparam int LOG_ITER = 24;
  localparam int LOG_LAT  = LOG_ITER + 1;

  // exp2 unit: first term in the entry stage, three stages for each later term
  localparam int EXP_TERMS = 13;
  localparam int EXP_LAT   = 1 + 3 * (EXP_TERMS - 1);

  // stages between the log2 outputs and the exp2 input
  localparam int MID_LAT = 5;

  // sideband travels from the entry stage to the low-temperature scaling stage
  localparam int DLY_SB = LOG_LAT + MID_LAT + EXP_LAT + 1;

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;

  // floor(2^32 / k)
  localparam logic [31:0] RECIP_TAB [2:13] = '{
    32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
    32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099
  };

  localparam logic signed [15:0] RST_OPTIMUM = 16'sd6400;
  localparam logic signed [15:0] RST_CUTOFF  = 16'sd10240;
  localparam logic [15:0]        RST_SHAPE   = 16'd819;

  localparam logic signed [15:0] LOW_TEMP_LIMIT = 16'sd1280;
  localparam logic [26:0]        LOW_TEMP_HALF  = 27'd640;
  localparam logic [15:0]        DIV5_MUL       = 16'd52429;
  localparam logic [16:0]        MULT_ONE       = 17'd32768;

  typedef enum logic [1:0] {
    CFG_OPTIMUM = 2'd0,
    CFG_CUTOFF  = 2'd1,
    CFG_SHAPE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic        zero;
    logic        lowt;
    logic [10:0] tlow;
  } sb_t;

  typedef struct packed {
    logic       sat;
    logic       zero2;
    logic [4:0] nsh;
  } e2f_t;

endpackage

// ===== rtl/trm_delay.sv =====
module trm_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// ===== rtl/trm_log2.sv =====
module trm_log2 import trm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x,
  output logic [27:0] log2_q
);

  logic [3:0]  msb;
  logic [30:0] y_r  [LOG_ITER+1];
  logic [23:0] fr_r [LOG_ITER+1];
  logic [3:0]  n_r  [LOG_ITER+1];

  // msb index
  always_comb begin
    msb = 4'd0;
    for (int b = 1; b < 16; b++) if (x[b]) msb = 4'(b);
  end

  // normalize mantissa to [1,2) in q30
  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]  <= 31'(x) << (5'd30 - {1'b0, msb});
      fr_r[0] <= '0;
      n_r[0]  <= msb;
    end
  end

  for (genvar i = 0; i < LOG_ITER; i++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] y2;
    assign sq = 62'(y_r[i]) * 62'(y_r[i]);
    assign y2 = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        y_r[i+1]  <= y2[31] ? y2[31:1] : y2[30:0];
        fr_r[i+1] <= {fr_r[i][22:0], y2[31]};
        n_r[i+1]  <= n_r[i];
      end
    end
  end

  assign log2_q = {n_r[LOG_ITER], fr_r[LOG_ITER]};

endmodule

// ===== rtl/trm_exp2.sv =====
module trm_exp2 import trm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] f,
  output logic [30:0] sum
);

  localparam int NT = EXP_TERMS - 1;

  logic [53:0] fx;
  logic [29:0] x_r    [NT+1];
  logic [29:0] term_r [NT+1];
  logic [30:0] sum_r  [NT+1];

  assign fx = 54'(f) * 54'(LN2_Q30);

  // entry stage holds the term x and the sum 1 + x
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= fx[53:24];
      term_r[0] <= fx[53:24];
      sum_r[0]  <= 31'(31'd1 << 30) + 31'(fx[53:24]);
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam logic [29:0] KV = 30'(j + 2);
    localparam logic [31:0] RV = RECIP_TAB[j + 2];

    logic [29:0] pa_r, xa_r, pb_r, qb_r, xb_r;
    logic [30:0] sa_r, sb_r;
    logic [59:0] tx;
    logic [61:0] pr;
    logic [29:0] qk, rem, tnext;

    assign tx    = 60'(term_r[j]) * 60'(x_r[j]);
    assign pr    = 62'(pa_r) * 62'(RV);
    assign qk    = qb_r * KV;
    assign rem   = pb_r - qk;
    assign tnext = qb_r + 30'(rem >= KV);

    always_ff @(posedge clk) begin
      if (en) begin
        // product stage
        pa_r <= tx[59:30];
        xa_r <= x_r[j];
        sa_r <= sum_r[j];
        // reciprocal stage, quotient low by at most one
        pb_r <= pa_r;
        qb_r <= pr[61:32];
        xb_r <= xa_r;
        sb_r <= sa_r;
        // correction and accumulate
        term_r[j+1] <= tnext;
        sum_r[j+1]  <= sb_r + 31'(tnext);
        x_r[j+1]    <= xb_r;
      end
    end
  end

  assign sum = sum_r[NT];

endmodule

// ===== rtl/temperature_response_multiplier.sv =====
// Temperature response multiplier: for each mean daytime air temperature
// (signed, 1/256 degree C) the block returns one unsigned Q1.15 multiplier
// ((tmax-T)/(tmax-topt))^((tmax-topt)*coef) * exp(coef*(T-topt)), scaled by
// T/5 below 5 degrees, zero below 0 or at and above the cutoff, saturated at
// 1.0, plus a flag when the cutoff is not above the optimum. The datapath is a
// fixed 71-stage pipeline taking a new temperature every cycle, its depth set
// by the 24 squaring stages of the log2 units and the 37 stages of the exp2
// series (three per term for the constant divide). A stall on the result side
// holds the whole pipeline; input stall is high only while a result waits and
// is stalled. Registers must be written through cfg_wr_en/cfg_index/cfg_data
// only while no transfers are in flight; the block does not enforce this.
module temperature_response_multiplier import trm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_air_temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_multiplier,
  output logic               out_config_error,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic signed [15:0] opt_r, cut_r;
  logic [15:0]        coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opt_r  <= RST_OPTIMUM;
      cut_r  <= RST_CUTOFF;
      coef_r <= RST_SHAPE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OPTIMUM: opt_r  <= cfg_data;
        CFG_CUTOFF:  cut_r  <= cfg_data;
        CFG_SHAPE:   coef_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // global advance: everything moves unless a finished result is held
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;

  // stage 1: range checks and differences
  logic [16:0] xa_nxt, dt_nxt, td_nxt;
  sb_t         sb1_nxt;
  sb_t         sb1_r;
  logic [15:0] xa_r, dt_r;
  logic signed [16:0] tdiff_r;

  assign xa_nxt = {cut_r[15], cut_r} - {in_air_temperature[15], in_air_temperature};
  assign dt_nxt = {cut_r[15], cut_r} - {opt_r[15], opt_r};
  assign td_nxt = {in_air_temperature[15], in_air_temperature} - {opt_r[15], opt_r};

  always_comb begin
    sb1_nxt.valid = in_valid;
    sb1_nxt.err   = !(cut_r > opt_r);
    sb1_nxt.zero  = in_air_temperature[15] || !(in_air_temperature < cut_r);
    sb1_nxt.lowt  = in_air_temperature < LOW_TEMP_LIMIT;
    sb1_nxt.tlow  = in_air_temperature[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r <= '0;
    end else if (en) begin
      sb1_r <= sb1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r    <= xa_nxt[15:0];
      dt_r    <= dt_nxt[15:0];
      tdiff_r <= td_nxt;
    end
  end

  // stages 2-3: coefficient products, run beside the log2 units
  logic [31:0]        dc_r;
  logic signed [33:0] tc_r;
  logic signed [59:0] tcl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r  <= 32'(dt_r) * 32'(coef_r);
      tc_r  <= tdiff_r * $signed({1'b0, coef_r});
      tcl_r <= tc_r * $signed({1'b0, LOG2E_Q24});
    end
  end

  logic [31:0] dc_d;
  logic [59:0] tcl_d;

  trm_delay #(.W(32), .DEPTH(LOG_LAT)) u_dly_dc (
    .clk(clk), .rst_n(rst_n), .en(en), .d(dc_r), .q(dc_d)
  );

  trm_delay #(.W(60), .DEPTH(LOG_LAT)) u_dly_tcl (
    .clk(clk), .rst_n(rst_n), .en(en), .d(tcl_r), .q(tcl_d)
  );

  // log2 of (cutoff - T) and of (cutoff - optimum)
  logic [27:0] la, lb;

  trm_log2 u_log_a (.clk(clk), .en(en), .x(xa_r), .log2_q(la));
  trm_log2 u_log_b (.clk(clk), .en(en), .x(dt_r), .log2_q(lb));

  // base-2 exponent, one wide operation per stage
  logic signed [28:0] l_r;
  logic signed [61:0] prod_r;
  logic signed [63:0] num_r;
  logic signed [63:0] rnd_sum;
  logic signed [43:0] e2_r;

  // half away from zero: negative side rounds up from half minus one
  assign rnd_sum = num_r + (num_r[63] ? 64'sd524287 : 64'sd524288);

  always_ff @(posedge clk) begin
    if (en) begin
      l_r    <= $signed({1'b0, la}) - $signed({1'b0, lb});
      prod_r <= l_r * $signed({1'b0, dc_d});
      num_r  <= {{2{prod_r[61]}}, prod_r} + {{4{tcl_d[59]}}, tcl_d};
      e2_r   <= rnd_sum[63:20];
    end
  end

  // split exponent into integer shift and fraction
  logic signed [19:0] e2_hi;
  e2f_t               e2f_nxt;
  e2f_t               e2f_r;
  logic [23:0]        frac_r;

  assign e2_hi = e2_r[43:24];

  always_comb begin
    e2f_nxt.sat   = !e2_r[43];
    e2f_nxt.zero2 = e2_hi < -20'sd16;
    e2f_nxt.nsh   = (~e2_hi[4:0]) + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2f_r  <= e2f_nxt;
      frac_r <= e2_r[23:0];
    end
  end

  logic [30:0] pow_frac;
  e2f_t        e2f_d;

  trm_exp2 u_exp2 (.clk(clk), .en(en), .f(frac_r), .sum(pow_frac));

  trm_delay #(.W($bits(e2f_t)), .DEPTH(EXP_LAT)) u_dly_e2f (
    .clk(clk), .rst_n(rst_n), .en(en), .d(e2f_r), .q(e2f_d)
  );

  // integer scaling with rounding, saturation at 1.0
  logic [4:0]  sh;
  logic [31:0] rnd_bit, t1, mq;
  logic [15:0] mult1_nxt, mult1_r;

  assign sh      = 5'd15 + e2f_d.nsh;
  assign rnd_bit = 32'd1 << (sh - 5'd1);
  assign t1      = {1'b0, pow_frac} + rnd_bit;
  assign mq      = t1 >> sh;

  always_comb begin
    priority if (e2f_d.sat)         mult1_nxt = MULT_ONE[15:0];
    else if (e2f_d.zero2)           mult1_nxt = '0;
    else if (mq > 32'(MULT_ONE))    mult1_nxt = MULT_ONE[15:0];
    else                            mult1_nxt = mq[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) mult1_r <= mult1_nxt;
  end

  // sideband catches up with the datapath here
  sb_t sb_d;
  sb_t sb2_r;

  trm_delay #(.W($bits(sb_t)), .DEPTH(DLY_SB)) u_dly_sb (
    .clk(clk), .rst_n(rst_n), .en(en), .d(sb1_r), .q(sb_d)
  );

  // low-temperature product, then divide by 1280 as >>8 and x/5 reciprocal
  logic [26:0] a_r;
  logic [15:0] mult2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb2_r <= '0;
    end else if (en) begin
      sb2_r <= sb_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= 27'(27'(mult1_r) * 27'(sb_d.tlow)) + LOW_TEMP_HALF;
      mult2_r <= mult1_r;
    end
  end

  logic [34:0] q5;
  logic [15:0] mult_out_nxt;
  logic [15:0] out_multiplier_r;
  logic        out_config_error_r;

  assign q5 = (35'(a_r[26:8]) * 35'(DIV5_MUL)) >> 18;

  always_comb begin
    priority if (sb2_r.err || sb2_r.zero) mult_out_nxt = '0;
    else if (sb2_r.lowt)                  mult_out_nxt = q5[15:0];
    else                                  mult_out_nxt = mult2_r;
  end

  // output register, holds while the transfer is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_multiplier_r   <= mult_out_nxt;
      out_config_error_r <= sb2_r.err;
    end
  end

  assign out_multiplier   = out_multiplier_r;
  assign out_config_error = out_config_error_r;

endmodule

// ===== rtl/trm_checker.sv =====
`include "assert_macros.svh"

module trm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_multiplier,
  input logic        out_config_error
);

  `TRM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_multiplier) && $stable(out_config_error))
  `TRM_ASSERT_NOW(a_err_zero, out_valid && out_config_error, out_multiplier == 16'd0)
  `TRM_ASSERT_NOW(a_range, out_valid, out_multiplier <= 16'd32768)
  `TRM_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)

endmodule

bind temperature_response_multiplier trm_checker u_trm_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import trm_pkg::*;

  // index 3 is outside the register file, writes to it must be dropped
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int unsigned FRAC_MASK = (1 << 24) - 1;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [15:0] multiplier;
    logic        config_error;
  } response_t;

  // golden response calculator plus the queue of pending responses
  class response_scoreboard;
    logic signed [15:0] optimum;
    logic signed [15:0] cutoff;
    logic [15:0]        shape;
    response_t          pending[$];
    int                 mismatches;
    int                 checked;

    function new();
      optimum = RST_OPTIMUM;
      cutoff = RST_CUTOFF;
      shape = RST_SHAPE;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_OPTIMUM) optimum = val;
      else if (idx == CFG_CUTOFF) cutoff = val;
      else if (idx == CFG_SHAPE) shape = val;
    endfunction

    // integer part is msb index, fraction from repeated squaring, truncated
    function longint log2_fixed(int unsigned x);
      int n;
      longint unsigned y;
      longint unsigned frac;
      n = 0;
      frac = 0;
      while (n < 15 && (x >> (n + 1)) != 0) n++;
      y = longint'(x) << (30 - n);
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 30;
        frac = frac << 1;
        if (y >= (64'd2 << 30)) begin
          frac = frac | 1;
          y = y >> 1;
        end
      end
      return longint'((longint'(n) << 24) | frac);
    endfunction

    // 2^f as q30 from a truncated taylor series of exp(f*ln2)
    function longint unsigned pow2_fraction(longint unsigned f);
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      x = (f * longint'(LN2_Q30)) >> 24;
      term = 64'd1 << 30;
      sum = term;
      for (int k = 1; k <= 13; k++) begin
        term = ((term * x) >> 30) / k;
        sum += term;
      end
      return sum;
    endfunction

    function response_t predict(logic signed [15:0] air);
      response_t r;
      longint t;
      longint dt;
      longint l;
      longint num;
      longint e2;
      longint unsigned m;
      longint unsigned f;
      longint unsigned n;
      longint unsigned mult;
      int sh;
      t = air;
      mult = 0;
      r.config_error = 1'b0;
      if (cutoff <= optimum) begin
        r.config_error = 1'b1;
      end else if (t >= 0 && t < cutoff) begin
        dt = longint'(cutoff) - longint'(optimum);
        l = log2_fixed(int'(longint'(cutoff) - t)) - log2_fixed(int'(dt));
        num = l * dt * longint'(shape)
            + (t - longint'(optimum)) * longint'(shape) * longint'(LOG2E_Q24);
        // divide by 2^20, halves rounded away from zero
        if (num >= 0) e2 = (num + (64'd1 << 19)) >> 20;
        else e2 = -(((-num) + (64'd1 << 19)) >> 20);
        if (e2 >= 0) begin
          mult = MULT_ONE;
        end else begin
          m = -e2;
          f = ((64'd1 << 24) - (m & FRAC_MASK)) & FRAC_MASK;
          n = (m + FRAC_MASK) >> 24;
          if (n < 17) begin
            sh = 15 + int'(n);
            mult = (pow2_fraction(f) + (64'd1 << (sh - 1))) >> sh;
          end
        end
        if (mult > MULT_ONE) mult = MULT_ONE;
        // linear fade-in below five degrees
        if (t < LOW_TEMP_LIMIT)
          mult = (mult * longint'(t) + LOW_TEMP_LIMIT / 2) / LOW_TEMP_LIMIT;
      end
      r.multiplier = mult[15:0];
      return r;
    endfunction

    function void note_input(logic signed [15:0] air);
      pending.push_back(predict(air));
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [15:0] mult, logic err);
      response_t want;
      if (pending.size() == 0) begin
        report("unexpected transfer, multiplier", mult, -1);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (mult !== want.multiplier) report("multiplier", mult, want.multiplier);
      if (err !== want.config_error) report("config_error", err, want.config_error);
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_air_temperature;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_multiplier;
  logic               out_config_error;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  response_scoreboard sb;
  logic quiet;      // when set neither side idles
  logic hold_req;   // asks the receiver for one long hold-off
  int   sent;
  int   phases;

  temperature_response_multiplier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_air_temperature(in_air_temperature),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_multiplier(out_multiplier), .out_config_error(out_config_error),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop if the pipeline hangs
  initial begin
    #20ms;
    $display("temperature_response_multiplier regression: fail");
    $finish;
  end

  // result side: random stall before each transfer, one long hold on request
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 15);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_multiplier, out_config_error);
  end

  // offer one temperature, keep valid high across back-to-back transfers
  task automatic send_temp(logic signed [15:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_air_temperature <= t;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    sent++;
  endtask

  // sender pauses until every pending response is back, then for DRAIN_CYCLES more
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_curve(logic [15:0] topt, logic [15:0] tmax, logic [15:0] coef);
    drain();
    write_reg(CFG_OPTIMUM, topt);
    write_reg(CFG_CUTOFF, tmax);
    write_reg(CFG_SHAPE, coef);
    phases++;
  endtask

  // mostly temperatures inside the live band, the rest anywhere
  function automatic logic signed [15:0] pick_temp();
    int hi;
    hi = int'(sb.cutoff);
    unique case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(0, 1400));
      3: return (hi > 4) ? 16'(hi - int'($urandom_range(1, 4))) : 16'sd0;
      default: return (hi > 1) ? 16'($urandom_range(0, hi - 1))
                               : 16'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic random_burst(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) quiet = ~quiet;
      send_temp(pick_temp());
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic signed [15:0] edge_temps[$];
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    phases = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_air_temperature = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_OPTIMUM;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset curve: range ends, the five degree knee, optimum and cutoff
    edge_temps = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd640, 16'sd1279,
                   16'sd1280, 16'sd1281, 16'sd3200, 16'sd6399, 16'sd6400,
                   16'sd6401, 16'sd8000, 16'sd10239, 16'sd10240, 16'sd10241,
                   16'sd32767, 16'sd21845, -16'sd21846};
    foreach (edge_temps[i]) send_temp(edge_temps[i]);

    // dead write to an unmapped index must leave the curve alone
    drain();
    write_reg(CFG_UNMAPPED, 16'h0000);
    send_temp(16'sd5000);
    send_temp(16'sd9000);

    // zero coefficient gives a flat curve, then the widest band at full shape
    set_curve(16'sd0, 16'sd32767, 16'd0);
    send_temp(16'sd0);
    send_temp(16'sd700);
    send_temp(16'sd32766);
    random_burst(100);
    set_curve(-16'sd32768, 16'sd32767, 16'd65535);
    random_burst(130);

    // cutoff at or below optimum flags an error for every temperature
    set_curve(16'sd32767, -16'sd32768, 16'd819);
    random_burst(40);
    set_curve(16'sd4000, 16'sd4000, 16'd819);
    random_burst(40);

    // narrow band just above zero
    set_curve(16'sd0, 16'sd1, 16'd65535);
    random_burst(60);

    // fill the pipeline against a long receiver hold-off
    set_curve(16'sd6400, 16'sd10240, 16'd819);
    hold_req = 1'b1;
    quiet = 1'b1;
    repeat (150) send_temp(pick_temp());
    quiet = 1'b0;
    random_burst(100);

    // random valid curves, some with the optimum below zero
    repeat (6) begin
      logic signed [15:0] a;
      logic signed [15:0] b;
      a = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12800));
      b = 16'(a + $urandom_range(1, 8000));
      if (b <= a) b = 16'sd32767;
      set_curve(a, b, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                 : 16'($urandom_range(0, 4096)));
      random_burst(110);
    end

    drain();
    $display("covered %0d temperatures over %0d register settings, %0d responses checked",
             sent, phases, sb.checked);
    $display("incl. error curves, flat curve, unmapped write and a long result hold-off");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("temperature_response_multiplier regression: pass");
    end else begin
      $display("temperature_response_multiplier regression: fail");
    end
    $finish;
  end

endmodule
